// File: hw/rtl/signed_divide_remainder_unit_defines.svh
// assertion macros shared by the divider rtl
`ifndef SIGNED_DIVIDE_REMAINDER_UNIT_DEFINES_SVH
`define SIGNED_DIVIDE_REMAINDER_UNIT_DEFINES_SVH

// checked at every rising edge, masked while reset is applied
`define SDR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every rising edge, reset included
`define SDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/sdr_pkg.sv
// shared types and constants of the signed divide and remainder unit
package sdr_pkg;

  localparam int unsigned DataW = 64;

  typedef enum logic {
    OP_QUOT = 1'b0,
    OP_REM  = 1'b1
  } op_e;

  typedef enum logic {
    ERR_NONE     = 1'b0,
    ERR_DIV_ZERO = 1'b1
  } err_e;

endpackage

// File: hw/rtl/sdr_in_if.sv
// operand channel: operation select, dividend and divisor
interface sdr_in_if
  import sdr_pkg::*;
();
  logic              valid;
  logic              ready;
  op_e               op;
  logic [DataW-1:0]  dividend;
  logic [DataW-1:0]  divisor;

  modport source (output valid, output op, output dividend, output divisor, input ready);
  modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface

// File: hw/rtl/sdr_out_if.sv
// result channel: quotient or remainder and error code
interface sdr_out_if
  import sdr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  result;
  err_e              error;

  modport source (output valid, output result, output error, input ready);
  modport sink   (input valid, input result, input error, output ready);
endinterface

// File: hw/rtl/signed_divide_remainder_unit.sv
// signed 64-bit divide / remainder unit, one restoring step per pipeline stage
//
// Fully pipelined signed 64-bit divider. Each transaction on in_i carries an
// operation select (quotient or remainder), a dividend and a divisor, and gives
// exactly one transaction on res_o, in order. The quotient truncates toward
// zero and the remainder takes the sign of the dividend. A zero divisor
// returns result 0 with error set to division by zero; the most negative value
// divided by -1 wraps to the most negative value. A new transaction can be
// taken every cycle while the output buffer is not full. Between acceptance
// and res_o, one stage takes the operand magnitudes, 64 stages each resolve one
// quotient bit with a 65-bit subtract and select, one stage restores the sign,
// and a two-entry output buffer presents the result. The whole pipeline moves
// together; it stops only while the output buffer holds two untaken results,
// so inputs keep flowing while a single finished result waits.
module signed_divide_remainder_unit
  import sdr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  sdr_in_if.sink  in_i,
  sdr_out_if.source res_o
);

  `include "signed_divide_remainder_unit_defines.svh"

  localparam int unsigned Steps     = DataW;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // working state carried down the pipeline
  typedef struct packed {
    logic [DataW-1:0] rem;    // partial remainder
    logic [DataW-1:0] quo;    // dividend bits shifting out, quotient bits shifting in
    logic [DataW-1:0] dvs;    // divisor magnitude
    logic             neg_q;  // quotient must be negated
    logic             neg_r;  // remainder must be negated
    op_e              op;
    logic             zero;   // divisor was zero
  } stage_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    err_e             error;
  } res_t;

  // pipeline advance: held only when the output buffer is full
  logic               en;
  logic               in_acc;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               wptr_q, rptr_q;
  logic               push, pop;

  logic [Steps:0]     valid_q;
  stage_t             pipe_q [0:Steps];
  logic               vout_q;
  res_t               out_q;
  res_t               out_d;
  res_t               fifo_q [0:FifoDepth-1];

  assign en          = (cnt_q != CntW'(FifoDepth));
  assign in_i.ready  = en;
  assign in_acc      = in_i.valid & en;

  // ---------------------------------------------------------------------------
  // valid bits travel with the data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vout_q  <= 1'b0;
    end else if (en) begin
      valid_q <= {valid_q[Steps-1:0], in_acc};
      vout_q  <= valid_q[Steps];
    end
  end

  // ---------------------------------------------------------------------------
  // entry stage: magnitudes and sign bookkeeping
  // ---------------------------------------------------------------------------
  stage_t entry_d;
  logic   neg_a, neg_b;

  always_comb begin
    neg_a         = in_i.dividend[DataW-1];
    neg_b         = in_i.divisor[DataW-1];
    entry_d.rem   = '0;
    entry_d.quo   = neg_a ? ('0 - in_i.dividend) : in_i.dividend;
    entry_d.dvs   = neg_b ? ('0 - in_i.divisor) : in_i.divisor;
    entry_d.neg_q = neg_a ^ neg_b;
    entry_d.neg_r = neg_a;
    entry_d.op    = in_i.op;
    entry_d.zero  = (in_i.divisor == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= entry_d;
    end
  end

  // ---------------------------------------------------------------------------
  // restoring division: one quotient bit per stage, msb first
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [DataW:0] shifted;
    logic [DataW:0] diff;
    stage_t         nxt_d;

    always_comb begin
      shifted = {pipe_q[k-1].rem, pipe_q[k-1].quo[DataW-1]};
      diff    = shifted - {1'b0, pipe_q[k-1].dvs};
      nxt_d   = pipe_q[k-1];
      // no borrow means the divisor fits into the partial remainder
      nxt_d.rem = diff[DataW] ? shifted[DataW-1:0] : diff[DataW-1:0];
      nxt_d.quo = {pipe_q[k-1].quo[DataW-2:0], ~diff[DataW]};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k] <= nxt_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // final stage: sign restore, zero divisor override
  // ---------------------------------------------------------------------------
  always_comb begin
    out_d.error  = ERR_NONE;
    out_d.result = '0;
    if (pipe_q[Steps].zero) begin
      out_d.error = ERR_DIV_ZERO;
    end else if (pipe_q[Steps].op == OP_QUOT) begin
      out_d.result = pipe_q[Steps].neg_q ? ('0 - pipe_q[Steps].quo) : pipe_q[Steps].quo;
    end else begin
      out_d.result = pipe_q[Steps].neg_r ? ('0 - pipe_q[Steps].rem) : pipe_q[Steps].rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // two-entry output buffer: decouples res_o.ready from the pipeline advance
  // ---------------------------------------------------------------------------
  assign push = en & vout_q;
  assign pop  = res_o.valid & res_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= out_q;
    end
  end

  assign res_o.valid  = (cnt_q != '0);
  assign res_o.result = fifo_q[rptr_q].result;
  assign res_o.error  = fifo_q[rptr_q].error;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SDR_ASSERT(a_accept_enters, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> valid_q[0], "accepted transaction did not enter the pipeline")
  `SDR_ASSERT(a_rem_below_dvs, clk_i, rst_ni, (valid_q[Steps] && !pipe_q[Steps].zero) |-> (pipe_q[Steps].rem < pipe_q[Steps].dvs), "final remainder not below divisor")
  `SDR_ASSERT(a_err_zero_res, clk_i, rst_ni, (res_o.valid && res_o.error == ERR_DIV_ZERO) |-> (res_o.result == '0), "division by zero with nonzero result")
  `SDR_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(FifoDepth), "output buffer count overflow")

endmodule
